// File: rtl/camrot_pkg.sv
// Shared types, constants and the operation sequence for the camera axis rotator.
package camrot_pkg;

  localparam int RegW    = 32;
  localparam int AccW    = 66;
  localparam int CordW   = 36;
  localparam int AtanLen = 24;
  localparam int ProgLen = 66;
  localparam int PcW     = 7;
  localparam int IterW   = 6;
  localparam int SqrtSteps = 32;

  localparam logic signed [CordW-1:0] CordicGain = 36'sd652032874;
  localparam logic signed [CordW-1:0] PiQ30      = 36'sd3373259426;
  localparam logic signed [CordW-1:0] HalfPiQ30  = 36'sd1686629713;

  typedef logic [4:0] reg_sel_t;

  // Operand and destination registers of the shared multiply-accumulate unit.
  localparam reg_sel_t R_V0  = 5'd0;
  localparam reg_sel_t R_U0  = 5'd3;
  localparam reg_sel_t R_A0  = 5'd6;
  localparam reg_sel_t R_C0  = 5'd9;
  localparam reg_sel_t R_CO  = 5'd12;
  localparam reg_sel_t R_SI  = 5'd13;
  localparam reg_sel_t R_OMC = 5'd14;
  localparam reg_sel_t R_DOT = 5'd15;
  localparam reg_sel_t R_K   = 5'd16;

  typedef logic [1:0] next_t;
  localparam next_t NX_CONT = 2'd0;
  localparam next_t NX_DONE = 2'd1;
  localparam next_t NX_CHK  = 2'd2;
  localparam next_t NX_NORM = 2'd3;

  typedef struct packed {
    reg_sel_t a_sel;
    reg_sel_t b_sel;
    reg_sel_t dst;
    logic     first;
    logic     sub;
    logic     rnd;
    logic     tsat;
    logic     wr;
    logic     wvec;
    next_t    nxt;
  } uop_t;

  typedef logic [3:0] cmd_op_t;
  localparam cmd_op_t CMD_NOP      = 4'd0;
  localparam cmd_op_t CMD_LOAD     = 4'd1;
  localparam cmd_op_t CMD_CSTEP    = 4'd2;
  localparam cmd_op_t CMD_CFIN     = 4'd3;
  localparam cmd_op_t CMD_MUL      = 4'd4;
  localparam cmd_op_t CMD_ACC      = 4'd5;
  localparam cmd_op_t CMD_SQ_INIT  = 4'd6;
  localparam cmd_op_t CMD_SQ_STEP  = 4'd7;
  localparam cmd_op_t CMD_DIV_INIT = 4'd8;
  localparam cmd_op_t CMD_DIV_STEP = 4'd9;
  localparam cmd_op_t CMD_DIV_FIN  = 4'd10;
  localparam cmd_op_t CMD_DEGEN    = 4'd11;
  localparam cmd_op_t CMD_OUT      = 4'd12;

  typedef struct packed {
    cmd_op_t          op;
    uop_t             uop;
    logic [IterW-1:0] iter;
    logic [1:0]       comp;
  } cmd_t;

  typedef struct packed {
    logic axis_zero;
  } status_t;

  function automatic logic signed [CordW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [CordW-1:0] r;
    unique case (idx)
      5'd0:  r = 36'sd843314857;
      5'd1:  r = 36'sd497837829;
      5'd2:  r = 36'sd263043837;
      5'd3:  r = 36'sd133525159;
      5'd4:  r = 36'sd67021687;
      5'd5:  r = 36'sd33543516;
      5'd6:  r = 36'sd16775851;
      5'd7:  r = 36'sd8388437;
      5'd8:  r = 36'sd4194283;
      5'd9:  r = 36'sd2097149;
      5'd10: r = 36'sd1048576;
      5'd11: r = 36'sd524288;
      5'd12: r = 36'sd262144;
      5'd13: r = 36'sd131072;
      5'd14: r = 36'sd65536;
      5'd15: r = 36'sd32768;
      5'd16: r = 36'sd16384;
      5'd17: r = 36'sd8192;
      5'd18: r = 36'sd4096;
      5'd19: r = 36'sd2048;
      5'd20: r = 36'sd1024;
      5'd21: r = 36'sd512;
      5'd22: r = 36'sd256;
      5'd23: r = 36'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

  // One of the six product terms of a cross product a x p written to dst.
  function automatic uop_t cross_uop(input logic [2:0] k, input reg_sel_t ab,
                                     input reg_sel_t pb, input reg_sel_t dst);
    uop_t u;
    logic [1:0] ai;
    logic [1:0] pidx;
    u = '0;
    unique case (k)
      3'd0: begin ai = 2'd1; pidx = 2'd2; end
      3'd1: begin ai = 2'd2; pidx = 2'd1; end
      3'd2: begin ai = 2'd2; pidx = 2'd0; end
      3'd3: begin ai = 2'd0; pidx = 2'd2; end
      3'd4: begin ai = 2'd0; pidx = 2'd1; end
      3'd5: begin ai = 2'd1; pidx = 2'd0; end
      default: begin ai = 2'd0; pidx = 2'd0; end
    endcase
    u.a_sel = ab + 5'(ai);
    u.b_sel = pb + 5'(pidx);
    u.first = ~k[0];
    u.sub   = k[0];
    u.rnd   = 1'b1;
    u.wr    = k[0];
    u.dst   = dst + 5'(k[2:1]);
    u.nxt   = NX_CONT;
    return u;
  endfunction

  // Rodrigues rotation of the vector at pb about the axis at ab, 19 steps.
  function automatic uop_t rot_uop(input logic [4:0] k, input reg_sel_t ab,
                                   input reg_sel_t pb);
    uop_t u;
    logic [4:0] m;
    logic [1:0] j;
    logic [1:0] t;
    u = '0;
    m = k - 5'd10;
    if (m < 5'd3) begin
      j = 2'd0; t = m[1:0];
    end else if (m < 5'd6) begin
      j = 2'd1; t = 2'(m - 5'd3);
    end else begin
      j = 2'd2; t = 2'(m - 5'd6);
    end
    if (k < 5'd6) begin
      u = cross_uop(k[2:0], ab, pb, R_C0);
    end else if (k < 5'd9) begin
      u.a_sel = ab + (k - 5'd6);
      u.b_sel = pb + (k - 5'd6);
      u.first = (k == 5'd6);
      u.rnd   = 1'b1;
      u.wr    = (k == 5'd8);
      u.dst   = R_DOT;
    end else if (k == 5'd9) begin
      u.a_sel = R_OMC;
      u.b_sel = R_DOT;
      u.first = 1'b1;
      u.rnd   = 1'b1;
      u.tsat  = 1'b1;
      u.wr    = 1'b1;
      u.dst   = R_K;
    end else begin
      u.rnd  = 1'b1;
      u.tsat = 1'b1;
      unique case (t)
        2'd0: begin
          u.a_sel = R_CO; u.b_sel = pb + 5'(j); u.first = 1'b1;
        end
        2'd1: begin
          u.a_sel = R_SI; u.b_sel = R_C0 + 5'(j);
        end
        default: begin
          u.a_sel = R_K; u.b_sel = ab + 5'(j);
          u.wr = 1'b1; u.wvec = 1'b1; u.dst = pb + 5'(j);
        end
      endcase
    end
    u.nxt = NX_CONT;
    return u;
  endfunction

  // Yaw runs from step 0; pitch runs from step 19.
  function automatic uop_t uop_at(input logic [PcW-1:0] pc);
    uop_t u;
    logic [PcW-1:0] j;
    u = '0;
    j = pc - 7'd25;
    if (pc < 7'd19) begin
      u = rot_uop(5'(pc), R_U0, R_V0);
      if (pc == 7'd18) u.nxt = NX_DONE;
    end else if (pc < 7'd25) begin
      u = cross_uop(3'(pc - 7'd19), R_U0, R_V0, R_A0);
      if (pc == 7'd24) u.nxt = NX_CHK;
    end else if (pc < 7'd28) begin
      u.a_sel = R_A0 + 5'(j);
      u.b_sel = R_A0 + 5'(j);
      u.first = (pc == 7'd25);
      if (pc == 7'd27) u.nxt = NX_NORM;
    end else if (pc < 7'd47) begin
      u = rot_uop(5'(pc - 7'd28), R_A0, R_V0);
    end else begin
      u = rot_uop(5'(pc - 7'd47), R_A0, R_U0);
      if (pc == 7'd65) u.nxt = NX_DONE;
    end
    return u;
  endfunction

endpackage

// File: rtl/camrot_ctrl.sv
// Sequencer for the camera axis rotator: handshakes, step counters and operation order.
module camrot_ctrl
  import camrot_pkg::*;
#(
  parameter int VEC_WIDTH    = 24,
  parameter int CORDIC_STEPS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  logic    in_mode,
  output logic    m_tvalid,
  input  logic    m_tready,
  output cmd_t    cmd,
  input  status_t status
);

  localparam int Steps   = (CORDIC_STEPS < AtanLen) ? CORDIC_STEPS : AtanLen;
  localparam int QuotW   = VEC_WIDTH - 7;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CORD = 4'd1;
  localparam logic [3:0] S_CFIN = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_ACC  = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_SQI  = 4'd6;
  localparam logic [3:0] S_SQ   = 4'd7;
  localparam logic [3:0] S_DVI  = 4'd8;
  localparam logic [3:0] S_DV   = 4'd9;
  localparam logic [3:0] S_DVF  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0]       state, state_next;
  logic [PcW-1:0]   pc, pc_next;
  logic [IterW-1:0] iter, iter_next;
  logic [1:0]       comp, comp_next;
  logic             m_tvalid_next;
  uop_t             cur;

  assign cur      = uop_at(pc);
  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    pc_next       = pc;
    iter_next     = iter;
    comp_next     = comp;
    m_tvalid_next = m_tvalid & ~m_tready;
    cmd           = '0;
    cmd.op        = CMD_NOP;
    cmd.uop       = cur;
    cmd.iter      = iter;
    cmd.comp      = comp;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = CMD_LOAD;
          iter_next  = '0;
          pc_next    = in_mode ? 7'd19 : 7'd0;
          state_next = S_CORD;
        end
      end
      S_CORD: begin
        cmd.op = CMD_CSTEP;
        if (iter == IterW'(Steps - 1)) begin
          state_next = S_CFIN;
        end else begin
          iter_next = iter + 1'b1;
        end
      end
      S_CFIN: begin
        cmd.op     = CMD_CFIN;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.op     = CMD_MUL;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.op = CMD_ACC;
        unique case (cur.nxt)
          NX_CONT: begin
            pc_next    = pc + 1'b1;
            state_next = S_MUL;
          end
          NX_DONE: state_next = S_OUT;
          NX_CHK:  state_next = S_CHK;
          default: state_next = S_SQI;
        endcase
      end
      S_CHK: begin
        if (status.axis_zero) begin
          cmd.op     = CMD_DEGEN;
          state_next = S_OUT;
        end else begin
          pc_next    = pc + 1'b1;
          state_next = S_MUL;
        end
      end
      S_SQI: begin
        cmd.op     = CMD_SQ_INIT;
        iter_next  = '0;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.op = CMD_SQ_STEP;
        if (iter == IterW'(SqrtSteps - 1)) begin
          comp_next  = '0;
          state_next = S_DVI;
        end else begin
          iter_next = iter + 1'b1;
        end
      end
      S_DVI: begin
        cmd.op     = CMD_DIV_INIT;
        iter_next  = '0;
        state_next = S_DV;
      end
      S_DV: begin
        cmd.op = CMD_DIV_STEP;
        if (iter == IterW'(QuotW - 1)) begin
          state_next = S_DVF;
        end else begin
          iter_next = iter + 1'b1;
        end
      end
      S_DVF: begin
        cmd.op = CMD_DIV_FIN;
        if (comp == 2'd2) begin
          pc_next    = pc + 1'b1;
          state_next = S_MUL;
        end else begin
          comp_next  = comp + 1'b1;
          state_next = S_DVI;
        end
      end
      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          cmd.op        = CMD_OUT;
          m_tvalid_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pc       <= '0;
      iter     <= '0;
      comp     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      pc       <= pc_next;
      iter     <= iter_next;
      comp     <= comp_next;
      m_tvalid <= m_tvalid_next;
    end
  end

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == S_CORD)
    else $error("accepted item did not start the sine and cosine pass");
  a_out_loads: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && (!m_tvalid || m_tready) |=> m_tvalid && state == S_IDLE)
    else $error("result not presented after finishing an item");
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> pc < 7'(ProgLen))
    else $error("operation step out of range");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !s_tready)
    else $error("input ready while an item is in progress");
`endif

endmodule

// File: rtl/camrot_dp.sv
// Datapath of the camera axis rotator: CORDIC, multiply-accumulate, square root and divider.
module camrot_dp
  import camrot_pkg::*;
#(
  parameter int VEC_WIDTH   = 24,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [ANGLE_WIDTH-1:0]   in_angle,
  input  cmd_t                     cmd,
  output status_t                  status,
  output logic [6*VEC_WIDTH-1:0]   res_vec,
  output logic                     res_degen
);

  localparam int VecFrac   = VEC_WIDTH - 8;
  localparam int AngleFrac = ANGLE_WIDTH - 3;
  localparam int QuotW     = VecFrac + 1;

  localparam logic signed [AccW-1:0] RndHalf  = AccW'(1) <<< (VecFrac - 1);
  localparam logic signed [AccW-1:0] Lim32    = AccW'(64'sh7FFF_FFFF);
  localparam logic signed [AccW-1:0] LimVec   = (AccW'(1) <<< (VEC_WIDTH - 1)) - AccW'(1);
  localparam logic signed [CordW-1:0] CordRnd = CordW'(1) <<< (29 - VecFrac);
  localparam logic signed [RegW-1:0] OneQ     = RegW'(1) <<< VecFrac;

  function automatic logic signed [AccW-1:0] clamp(input logic signed [AccW-1:0] v,
                                                   input logic signed [AccW-1:0] lim);
    logic signed [AccW-1:0] r;
    if (v > lim) r = lim;
    else if (v < -lim - AccW'(1)) r = -lim - AccW'(1);
    else r = v;
    return r;
  endfunction

  logic signed [VEC_WIDTH-1:0] v [3];
  logic signed [VEC_WIDTH-1:0] u [3];
  logic signed [RegW-1:0]      a [3];
  logic signed [RegW-1:0]      c [3];
  logic signed [RegW-1:0]      co, si, omc, dot, kk;
  logic signed [CordW-1:0]     cx, cy, cz;
  logic                        flip;
  logic signed [63:0]          prod;
  logic signed [AccW-1:0]      acc;
  logic [63:0]                 sq_v, sq_r, sq_b;
  logic [63:0]                 dv_rem, dv_d;
  logic [QuotW-1:0]            dv_q;
  logic                        dv_neg;
  logic                        degen;

  logic signed [RegW-1:0]      op_a, op_b;
  logic signed [AccW-1:0]      prod_x, term_r, term, acc_new, wval;
  logic signed [CordW-1:0]     z0, z_load, x_f, y_f, co_w, si_w;
  logic                        flip_load;
  logic signed [CordW-1:0]     dx, dy;
  logic [63:0]                 sq_t;
  logic signed [RegW-1:0]      a_sel_c;
  logic signed [63:0]          a_ext;
  logic [63:0]                 mag;

  always_comb begin
    unique case (cmd.uop.a_sel)
      5'd0: op_a = RegW'(v[0]);
      5'd1: op_a = RegW'(v[1]);
      5'd2: op_a = RegW'(v[2]);
      5'd3: op_a = RegW'(u[0]);
      5'd4: op_a = RegW'(u[1]);
      5'd5: op_a = RegW'(u[2]);
      5'd6: op_a = a[0];
      5'd7: op_a = a[1];
      5'd8: op_a = a[2];
      5'd9: op_a = c[0];
      5'd10: op_a = c[1];
      5'd11: op_a = c[2];
      R_CO:  op_a = co;
      R_SI:  op_a = si;
      R_OMC: op_a = omc;
      R_DOT: op_a = dot;
      R_K:   op_a = kk;
      default: op_a = '0;
    endcase
    unique case (cmd.uop.b_sel)
      5'd0: op_b = RegW'(v[0]);
      5'd1: op_b = RegW'(v[1]);
      5'd2: op_b = RegW'(v[2]);
      5'd3: op_b = RegW'(u[0]);
      5'd4: op_b = RegW'(u[1]);
      5'd5: op_b = RegW'(u[2]);
      5'd6: op_b = a[0];
      5'd7: op_b = a[1];
      5'd8: op_b = a[2];
      5'd9: op_b = c[0];
      5'd10: op_b = c[1];
      5'd11: op_b = c[2];
      R_CO:  op_b = co;
      R_SI:  op_b = si;
      R_OMC: op_b = omc;
      R_DOT: op_b = dot;
      R_K:   op_b = kk;
      default: op_b = '0;
    endcase
  end

  // Product term, optionally rounded and saturated, then added into or subtracted from the accumulator.
  always_comb begin
    prod_x  = AccW'(prod);
    term_r  = cmd.uop.rnd ? ((prod_x + RndHalf) >>> VecFrac) : prod_x;
    term    = cmd.uop.tsat ? clamp(term_r, Lim32) : term_r;
    acc_new = (cmd.uop.first ? AccW'(0) : acc) + (cmd.uop.sub ? -term : term);
    wval    = cmd.uop.wvec ? clamp(acc_new, LimVec) : clamp(acc_new, Lim32);
  end

  // Angles beyond a quarter turn are folded by half a turn and the result negated.
  always_comb begin
    z0 = CordW'($signed(in_angle)) <<< (30 - AngleFrac);
    flip_load = 1'b0;
    z_load = z0;
    if (z0 > HalfPiQ30) begin
      z_load = z0 - PiQ30;
      flip_load = 1'b1;
    end else if (z0 < -HalfPiQ30) begin
      z_load = z0 + PiQ30;
      flip_load = 1'b1;
    end
    dx   = cy >>> cmd.iter;
    dy   = cx >>> cmd.iter;
    x_f  = flip ? -cx : cx;
    y_f  = flip ? -cy : cy;
    co_w = (x_f + CordRnd) >>> (30 - VecFrac);
    si_w = (y_f + CordRnd) >>> (30 - VecFrac);
  end

  always_comb begin
    sq_t = sq_r + sq_b;
    unique case (cmd.comp)
      2'd0: a_sel_c = a[0];
      2'd1: a_sel_c = a[1];
      default: a_sel_c = a[2];
    endcase
    a_ext = 64'(a_sel_c);
    mag   = a_ext[63] ? 64'(-a_ext) : 64'(a_ext);
  end

  assign status.axis_zero = (a[0] == '0) && (a[1] == '0) && (a[2] == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0]  <= '0;
      v[1]  <= '0;
      v[2]  <= VEC_WIDTH'(7) <<< VecFrac;
      u[0]  <= '0;
      u[1]  <= VEC_WIDTH'(1) <<< VecFrac;
      u[2]  <= '0;
      degen <= 1'b0;
    end else begin
      unique case (cmd.op)
        CMD_LOAD: begin
          cx    <= CordicGain;
          cy    <= '0;
          cz    <= z_load;
          flip  <= flip_load;
          degen <= 1'b0;
        end
        CMD_CSTEP: begin
          if (!cz[CordW-1]) begin
            cx <= cx - dx;
            cy <= cy + dy;
            cz <= cz - atan_q30(cmd.iter[4:0]);
          end else begin
            cx <= cx + dx;
            cy <= cy - dy;
            cz <= cz + atan_q30(cmd.iter[4:0]);
          end
        end
        CMD_CFIN: begin
          co  <= RegW'(co_w);
          si  <= RegW'(si_w);
          omc <= OneQ - RegW'(co_w);
        end
        CMD_MUL: begin
          prod <= 64'(op_a) * 64'(op_b);
        end
        CMD_ACC: begin
          acc <= acc_new;
          if (cmd.uop.wr) begin
            unique case (cmd.uop.dst)
              5'd0: v[0] <= VEC_WIDTH'(wval);
              5'd1: v[1] <= VEC_WIDTH'(wval);
              5'd2: v[2] <= VEC_WIDTH'(wval);
              5'd3: u[0] <= VEC_WIDTH'(wval);
              5'd4: u[1] <= VEC_WIDTH'(wval);
              5'd5: u[2] <= VEC_WIDTH'(wval);
              5'd6: a[0] <= RegW'(wval);
              5'd7: a[1] <= RegW'(wval);
              5'd8: a[2] <= RegW'(wval);
              5'd9: c[0] <= RegW'(wval);
              5'd10: c[1] <= RegW'(wval);
              5'd11: c[2] <= RegW'(wval);
              R_DOT: dot <= RegW'(wval);
              R_K:   kk  <= RegW'(wval);
              default: ;
            endcase
          end
        end
        CMD_SQ_INIT: begin
          sq_v <= acc[63:0];
          sq_r <= '0;
          sq_b <= 64'd1 << 62;
        end
        CMD_SQ_STEP: begin
          if (sq_v >= sq_t) begin
            sq_v <= sq_v - sq_t;
            sq_r <= (sq_r >> 1) + sq_b;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_b <= sq_b >> 2;
        end
        CMD_DIV_INIT: begin
          dv_rem <= (mag << VecFrac) + (sq_r >> 1);
          dv_d   <= sq_r << (QuotW - 1);
          dv_q   <= '0;
          dv_neg <= a_ext[63];
        end
        CMD_DIV_STEP: begin
          if (dv_rem >= dv_d) begin
            dv_rem <= dv_rem - dv_d;
            dv_q   <= {dv_q[QuotW-2:0], 1'b1};
          end else begin
            dv_q   <= {dv_q[QuotW-2:0], 1'b0};
          end
          dv_d <= dv_d >> 1;
        end
        CMD_DIV_FIN: begin
          unique case (cmd.comp)
            2'd0: a[0] <= dv_neg ? -RegW'(dv_q) : RegW'(dv_q);
            2'd1: a[1] <= dv_neg ? -RegW'(dv_q) : RegW'(dv_q);
            default: a[2] <= dv_neg ? -RegW'(dv_q) : RegW'(dv_q);
          endcase
        end
        CMD_DEGEN: degen <= 1'b1;
        CMD_OUT: begin
          res_vec   <= {u[2], u[1], u[0], v[2], v[1], v[0]};
          res_degen <= degen;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/camera_axis_rotator_unit.sv
// Camera axis rotator: keeps a view and an up vector in fixed point and turns the view (yaw) or both (pitch) per item.
// Each input item carries a mode in s_tuser (0 yaw about the up vector, 1 pitch about the
// normalized up x view axis) and a signed Q3.13 angle in s_tdata. Every item gives one result
// item with both vectors in Q8.16 on m_tdata and the degenerate flag on m_tuser. Items are
// handled one at a time. The CORDIC runs S = min(CORDIC_STEPS, 24) iterations; the shared
// 32x32 multiply-accumulate unit, the one-bit-per-cycle square root and the restoring divider
// do the vector arithmetic. A finished result waits in an output register, so the next item
// is accepted while it is still pending.
module camera_axis_rotator_unit
  import camrot_pkg::*;
#(
  parameter int VEC_WIDTH    = 24,
  parameter int ANGLE_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // angle
  input  logic [((ANGLE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  // mode
  input  logic [0:0]                              s_tuser,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // view_x, view_y, view_z, upvec_x, upvec_y, upvec_z
  output logic [((6 * VEC_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
  // degenerate
  output logic [0:0]                              m_tuser
);

  localparam int OutW = ((6 * VEC_WIDTH + 7) / 8) * 8;

  cmd_t                   cmd;
  status_t                status;
  logic [6*VEC_WIDTH-1:0] res_vec;
  logic                   res_degen;

  camrot_ctrl #(
    .VEC_WIDTH    (VEC_WIDTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .in_mode  (s_tuser[0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  camrot_dp #(
    .VEC_WIDTH   (VEC_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_angle  (s_tdata[ANGLE_WIDTH-1:0]),
    .cmd       (cmd),
    .status    (status),
    .res_vec   (res_vec),
    .res_degen (res_degen)
  );

  assign m_tdata    = OutW'(res_vec);
  assign m_tuser[0] = res_degen;

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the camera axis rotator: directed table, then random moves.
`timescale 1ns / 100ps

module testbench;

  localparam int VW = 24;
  localparam int FR = VW - 8;
  localparam int NUM_RANDOM = 830;
  localparam int STALL_LIMIT = 6000;

  typedef longint vec3_t [3];

  typedef struct {
    logic [VW-1:0] f [6];
    logic          degenerate;
  } pose_t;

  typedef struct {
    logic        mode;
    logic [15:0] angle;
    logic        deg_known;
    logic        deg_value;
  } move_row_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [15:0] s_tdata;
  logic [0:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [143:0] m_tdata;
  logic [0:0] m_tuser;

  vec3_t cam_view;
  vec3_t cam_up;
  pose_t pending_poses[$];
  move_row_t deg_checks[$];
  int errors;
  int idle_cycles;
  bit no_idle;

  camera_axis_rotator_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint rshift_round(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint clamp32(longint v);
    return clamp(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic longint fxmul(longint a, longint b);
    return clamp32(rshift_round(a * b, FR));
  endfunction

  function automatic void cross_fx(input vec3_t a, input vec3_t b, output vec3_t r);
    r[0] = clamp32(rshift_round(a[1] * b[2], FR) - rshift_round(a[2] * b[1], FR));
    r[1] = clamp32(rshift_round(a[2] * b[0], FR) - rshift_round(a[0] * b[2], FR));
    r[2] = clamp32(rshift_round(a[0] * b[1], FR) - rshift_round(a[1] * b[0], FR));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void cordic_sincos(input longint ang, output longint co,
                                        output longint si);
    longint z;
    longint x;
    longint y;
    longint dx;
    longint dy;
    bit flip;
    longint atan_tab [16];
    atan_tab = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                 131072, 65536, 32768};
    z = ang * 131072;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426; flip = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426; flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    co = rshift_round(x, 30 - FR);
    si = rshift_round(y, 30 - FR);
  endfunction

  function automatic void rodrigues_turn(input vec3_t a, input longint co, input longint si,
                                         inout vec3_t p);
    vec3_t cr;
    vec3_t res;
    longint dot;
    longint k;
    cross_fx(a, p, cr);
    dot = clamp32(rshift_round(a[0] * p[0], FR) + rshift_round(a[1] * p[1], FR)
                  + rshift_round(a[2] * p[2], FR));
    k = fxmul((longint'(1) <<< FR) - co, dot);
    for (int j = 0; j < 3; j++)
      res[j] = clamp(fxmul(co, p[j]) + fxmul(si, cr[j]) + fxmul(k, a[j]),
                     -(longint'(1) <<< (VW - 1)), (longint'(1) <<< (VW - 1)) - 1);
    p = res;
  endfunction

  function automatic pose_t camera_move(logic mode, logic [15:0] angle);
    pose_t r;
    longint co;
    longint si;
    vec3_t ax;
    longint unsigned sq;
    longint unsigned n;
    longint unsigned mag;
    longint q;
    r.degenerate = 1'b0;
    cordic_sincos(longint'($signed(angle)), co, si);
    if (mode == 1'b0) begin
      rodrigues_turn(cam_up, co, si, cam_view);
    end else begin
      cross_fx(cam_up, cam_view, ax);
      if (ax[0] == 0 && ax[1] == 0 && ax[2] == 0) begin
        r.degenerate = 1'b1;
      end else begin
        sq = 0;
        for (int j = 0; j < 3; j++) sq += longint'(ax[j] * ax[j]);
        n = int_sqrt(sq);
        for (int j = 0; j < 3; j++) begin
          mag = ax[j] < 0 ? -ax[j] : ax[j];
          q = ((mag << FR) + (n >> 1)) / n;
          ax[j] = ax[j] < 0 ? -q : q;
        end
        rodrigues_turn(ax, co, si, cam_view);
        rodrigues_turn(ax, co, si, cam_up);
      end
    end
    for (int j = 0; j < 3; j++) begin
      r.f[j] = cam_view[j][VW-1:0];
      r.f[3+j] = cam_up[j][VW-1:0];
    end
    return r;
  endfunction

  // Predict on every accepted item.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) pending_poses.push_back(camera_move(s_tuser[0], s_tdata));
  end

  always @(posedge clk) begin
    pose_t e;
    move_row_t d;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_poses.size() == 0) begin
        $display("%0t: result item with nothing expected", $time);
        errors++;
      end else begin
        e = pending_poses.pop_front();
        for (int j = 0; j < 6; j++)
          if (m_tdata[j*VW +: VW] !== e.f[j]) begin
            $display("%0t: field %0d expected %h actual %h", $time, j, e.f[j],
                     m_tdata[j*VW +: VW]);
            errors++;
          end
        if (m_tuser[0] !== e.degenerate) begin
          $display("%0t: degenerate expected %b actual %b", $time, e.degenerate, m_tuser[0]);
          errors++;
        end
        if (deg_checks.size() != 0) begin
          d = deg_checks.pop_front();
          if (d.deg_known && m_tuser[0] !== d.deg_value) begin
            $display("%0t: table degenerate expected %b actual %b", $time, d.deg_value,
                     m_tuser[0]);
            errors++;
          end
        end
      end
    end
  end

  // Receiver stalls: mostly short, now and then long.
  int rx_stall;
  always @(negedge clk) begin
    if (rst || no_idle) begin
      m_tready <= !rst;
      rx_stall <= 0;
    end else if (rx_stall > 0) begin
      m_tready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else if ($urandom_range(0, 60) == 0) begin
      m_tready <= 1'b0;
      rx_stall <= int'($urandom_range(20, 250));
    end else begin
      m_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("camera_axis_rotator_unit verification failed");
      $finish;
    end
  end

  task automatic send_move(logic mode, logic [15:0] angle, bit last);
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= angle;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (last || (!no_idle && $urandom_range(0, 2) == 0)) begin
      s_tvalid <= 1'b0;
      s_tdata <= 16'($urandom);
      if (!no_idle) begin
        if ($urandom_range(0, 40) == 0) repeat ($urandom_range(40, 200)) @(negedge clk);
        else repeat ($urandom_range(1, 4)) @(negedge clk);
      end
    end
  endtask

  move_row_t moves [$];
  logic [15:0] ang;
  int drain;

  initial begin
    errors = 0;
    no_idle = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    cam_view = '{0, 0, 7 <<< FR};
    cam_up = '{0, 1 <<< FR, 0};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Zero, both extremes, the quarter-turn fold boundaries, half turns, unit steps and other angles, in both modes.
    moves = '{
      '{1'b0, 16'h0000, 1'b1, 1'b0}, '{1'b1, 16'h0000, 1'b1, 1'b0},
      '{1'b0, 16'h7fff, 1'b1, 1'b0}, '{1'b0, 16'h8000, 1'b1, 1'b0},
      '{1'b1, 16'h7fff, 1'b0, 1'b0}, '{1'b1, 16'h8000, 1'b0, 1'b0},
      '{1'b0, 16'd12867, 1'b1, 1'b0}, '{1'b0, 16'd12868, 1'b1, 1'b0},
      '{1'b0, -16'sd12867, 1'b1, 1'b0}, '{1'b0, -16'sd12868, 1'b1, 1'b0},
      '{1'b1, 16'd12868, 1'b0, 1'b0}, '{1'b1, -16'sd12868, 1'b0, 1'b0},
      '{1'b0, 16'd25736, 1'b1, 1'b0}, '{1'b1, 16'd25736, 1'b0, 1'b0},
      '{1'b0, 16'h0001, 1'b1, 1'b0}, '{1'b1, 16'hffff, 1'b0, 1'b0},
      '{1'b1, 16'd410, 1'b0, 1'b0}, '{1'b0, -16'sd410, 1'b1, 1'b0},
      '{1'b1, 16'h5555, 1'b0, 1'b0}, '{1'b0, 16'haaaa, 1'b1, 1'b0}
    };
    foreach (moves[i]) begin
      deg_checks.push_back(moves[i]);
      send_move(moves[i].mode, moves[i].angle, 1'b0);
    end

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 400) begin
        s_tvalid <= 1'b0;
        wait (pending_poses.size() == 0);
        @(negedge clk);
      end
      no_idle = (i >= 600 && i < 680);
      if ($urandom_range(0, 9) < 7) begin
        ang = 16'($urandom_range(0, 4000));
        if ($urandom_range(0, 1)) ang = -ang;
      end else begin
        ang = 16'($urandom);
      end
      deg_checks.push_back('{1'b0, 16'h0, 1'b0, 1'b0});
      send_move(1'($urandom_range(0, 1)), ang, i == NUM_RANDOM - 1);
    end

    drain = 0;
    while (pending_poses.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (250) @(posedge clk);
    if (errors == 0 && pending_poses.size() == 0) begin
      $display("camera_axis_rotator_unit verification clean");
    end else begin
      $display("camera_axis_rotator_unit verification failed");
    end
    $finish;
  end

endmodule

// File: camera_axis_rotator_unit.f
rtl/camrot_pkg.sv
rtl/camrot_ctrl.sv
rtl/camrot_dp.sv
rtl/camera_axis_rotator_unit.sv
sim/testbench.sv
